// File: design/assert_macros.svh
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: design/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg
// Types, constants and helpers for the sculling leg trajectory core.
// ----------------------------------------------------------------------------
`default_nettype none

package slt_pkg;

    localparam int CORDIC_STAGES_DEF   = 16;
    localparam int PHASE_FRAC_BITS_DEF = 16;
    localparam int ATAN_ENTRIES        = 24;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_SWING_AMPLITUDE = 2'd0;
    localparam logic [1:0] REG_MEAN_ANGLE      = 2'd1;
    localparam logic [1:0] REG_CENTER_HEIGHT   = 2'd2;
    localparam logic [1:0] REG_ARC_RADIUS      = 2'd3;

    localparam logic [14:0] RST_SWING_AMPLITUDE = 15'd4608;
    localparam logic signed [15:0] RST_MEAN_ANGLE = -16'sd4608;
    localparam logic signed [15:0] RST_CENTER_HEIGHT = -16'sd832;
    localparam logic [15:0] RST_ARC_RADIUS = 16'd1616;

    // CORDIC datapath: Q30 values in 33 bits, angles in binary turns
    localparam int DW = 33;
    localparam logic signed [DW-1:0] CORDIC_GAIN_INV = 33'sd652032874;
    localparam logic signed [DW-1:0] Q30_HALF        = 33'sd536870912;
    localparam logic [31:0] QUADRANT_OFFSET          = 32'h2000_0000;

    // Degrees-to-turns conversion: 2^21 = 45 * 46603 + 17, floor(w/45) by reciprocal
    localparam logic [16:0] DEG256_PER_TURN = 17'd92160;
    localparam logic [15:0] TURN_QUOT       = 16'd46603;
    localparam logic [4:0]  TURN_REM        = 5'd17;
    localparam logic [4:0]  TURN_BIAS       = 5'd22;
    localparam logic [20:0] RECIP_45        = 21'd1491309;
    localparam int          RECIP_SHIFT     = 26;

    localparam logic signed [49:0] OUT_MAX = 50'sd131071;
    localparam logic signed [49:0] OUT_MIN = -50'sd131072;

    localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41721,     32'd20860,
        32'd10430,     32'd5215,      32'd2607,      32'd1303,
        32'd651,       32'd325,       32'd162,       32'd81
    };

    // One CORDIC cell's contents
    typedef struct packed {
        logic                 vld;
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [DW-1:0] z;
        logic [1:0]           quad;
        logic                 flag;
    } cdc_t;

    // Cosine and sine leaving a CORDIC chain
    typedef struct packed {
        logic                 vld;
        logic signed [DW-1:0] cos_q30;
        logic signed [DW-1:0] sin_q30;
        logic                 flag;
    } cs_t;

    function automatic logic signed [17:0] sat18(input logic signed [49:0] v);
        logic signed [49:0] r;
        begin
            if (v > OUT_MAX)
            begin
                r = OUT_MAX;
            end
            else if (v < OUT_MIN)
            begin
                r = OUT_MIN;
            end
            else
            begin
                r = v;
            end
            return r[17:0];
        end
    endfunction

endpackage

`default_nettype wire

// File: design/slt_cordic_cell.sv
// ----------------------------------------------------------------------------
// slt_cordic_cell
// One micro-rotation of a rotation-mode CORDIC, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_cordic_cell #(
    parameter int STAGE = 0
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire slt_pkg::cdc_t cell_in,
    output slt_pkg::cdc_t      cell_out
);

    slt_pkg::cdc_t cell_reg;
    slt_pkg::cdc_t cell_next;
    logic signed [slt_pkg::DW-1:0] atan_val;

    assign atan_val = signed'({1'b0, slt_pkg::ATAN_TURNS[STAGE]});

    // Rotate towards zero residual angle
    always_comb
    begin
        cell_next = cell_in;
        if (!cell_in.z[slt_pkg::DW-1])
        begin
            cell_next.x = cell_in.x - (cell_in.y >>> STAGE);
            cell_next.y = cell_in.y + (cell_in.x >>> STAGE);
            cell_next.z = cell_in.z - atan_val;
        end
        else
        begin
            cell_next.x = cell_in.x + (cell_in.y >>> STAGE);
            cell_next.y = cell_in.y - (cell_in.x >>> STAGE);
            cell_next.z = cell_in.z + atan_val;
        end
    end

    // Advance when the pipe moves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

`default_nettype wire

// File: design/slt_cordic.sv
// ----------------------------------------------------------------------------
// slt_cordic
// Chain of CORDIC cells: quadrant split, micro-rotations, quadrant fold-back.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_cordic #(
    parameter int STAGES = slt_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        in_vld,
    input  wire logic [31:0] turns,
    input  wire logic        flag,
    output slt_pkg::cs_t     result
);

    slt_pkg::cdc_t chain [STAGES+1];
    logic [31:0]   shifted;
    slt_pkg::cdc_t last;

    // Split into nearest quadrant and residual angle
    assign shifted = turns + slt_pkg::QUADRANT_OFFSET;

    assign chain[0].vld  = in_vld;
    assign chain[0].x    = slt_pkg::CORDIC_GAIN_INV;
    assign chain[0].y    = '0;
    assign chain[0].z    = signed'({3'b000, shifted[29:0]}) - slt_pkg::Q30_HALF;
    assign chain[0].quad = shifted[31:30];
    assign chain[0].flag = flag;

    for (genvar g = 0; g < STAGES; g++)
    begin : g_cell
        slt_cordic_cell #(
            .STAGE (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .cell_in  (chain[g]),
            .cell_out (chain[g+1])
        );
    end

    assign last = chain[STAGES];

    // Fold the quadrant back into cosine and sine
    always_comb
    begin
        result.vld  = last.vld;
        result.flag = last.flag;
        unique case (last.quad)
            2'd0:
            begin
                result.cos_q30 = last.x;
                result.sin_q30 = last.y;
            end
            2'd1:
            begin
                result.cos_q30 = -last.y;
                result.sin_q30 = last.x;
            end
            2'd2:
            begin
                result.cos_q30 = -last.x;
                result.sin_q30 = -last.y;
            end
            default:
            begin
                result.cos_q30 = last.y;
                result.sin_q30 = -last.x;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/sculling_leg_trajectory_core.sv
// Throughput: one word per cycle; the whole pipe advances together and halts
// only while the output register holds a word not yet taken.
// Reset: clears all valid flags and loads the register defaults.
// ----------------------------------------------------------------------------
// sculling_leg_trajectory_core
// Gait phase to foot position through two chained CORDIC pipelines.
// ----------------------------------------------------------------------------
`default_nettype none

module sculling_leg_trajectory_core #(
    parameter int CORDIC_STAGES   = slt_pkg::CORDIC_STAGES_DEF,
    parameter int PHASE_FRAC_BITS = slt_pkg::PHASE_FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_addr,
    input  wire logic [15:0]        cfg_wdata,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] gait_phase,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [17:0]      foot_y,
    output logic signed [17:0]      foot_z,
    output logic                    power_stroke
);

    logic [14:0]        amp_reg;
    logic signed [15:0] mean_reg;
    logic signed [15:0] center_reg;
    logic [15:0]        radius_reg;

    logic        adv;
    logic [31:0] turns1;
    slt_pkg::cs_t cs1;
    slt_pkg::cs_t cs2;

    logic               m1_vld_reg;
    logic signed [48:0] m1_prod_reg;
    logic signed [49:0] delta_full;
    logic signed [19:0] theta;
    logic [16:0]        tm_next;

    logic        d_vld_reg;
    logic [16:0] tm_reg;
    logic        d_pw_reg;

    logic [20:0] w_val;
    logic [41:0] qw_full;
    logic        r_vld_reg;
    logic [32:0] r_p1_reg;
    logic [15:0] r_qw_reg;
    logic        r_pw_reg;
    logic [31:0] turns2;

    logic               m2_vld_reg;
    logic signed [49:0] m2_py_reg;
    logic signed [49:0] m2_pz_reg;
    logic               m2_pw_reg;
    logic signed [49:0] ry;
    logic signed [49:0] rz;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_reg    <= slt_pkg::RST_SWING_AMPLITUDE;
            mean_reg   <= slt_pkg::RST_MEAN_ANGLE;
            center_reg <= slt_pkg::RST_CENTER_HEIGHT;
            radius_reg <= slt_pkg::RST_ARC_RADIUS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                slt_pkg::REG_SWING_AMPLITUDE: amp_reg    <= cfg_wdata[14:0];
                slt_pkg::REG_MEAN_ANGLE:      mean_reg   <= signed'(cfg_wdata);
                slt_pkg::REG_CENTER_HEIGHT:   center_reg <= signed'(cfg_wdata);
                default:                      radius_reg <= cfg_wdata;
            endcase
        end
    end

    // Whole pipe moves unless the output word is stuck
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    // Phase fraction to turns
    assign turns1 = 32'(gait_phase[PHASE_FRAC_BITS-1:0]) << (32 - PHASE_FRAC_BITS);

    slt_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic_phase (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (adv),
        .in_vld (in_valid),
        .turns  (turns1),
        .flag   (1'b0),
        .result (cs1)
    );

    // Scale sine by the swing amplitude
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            m1_vld_reg <= cs1.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_prod_reg <= 49'(signed'({1'b0, amp_reg})) * 49'(cs1.sin_q30);
        end
    end

    // Round, add the mean and wrap into one turn
    assign delta_full = (50'(m1_prod_reg) + 50'(slt_pkg::Q30_HALF)) >>> 30;
    assign theta      = 20'(mean_reg) + delta_full[19:0];
    assign tm_next    = theta[19] ? 17'(theta + signed'({3'b000, slt_pkg::DEG256_PER_TURN}))
                                  : theta[16:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            d_vld_reg <= m1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tm_reg   <= tm_next;
            d_pw_reg <= (delta_full > 50'sd0);
        end
    end

    // Degrees to turns: quotient part and remainder part divided by 45
    assign w_val   = 21'(tm_reg) * 21'(slt_pkg::TURN_REM) + 21'(slt_pkg::TURN_BIAS);
    assign qw_full = 42'(w_val) * 42'(slt_pkg::RECIP_45);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            r_vld_reg <= d_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_p1_reg <= 33'(tm_reg) * 33'(slt_pkg::TURN_QUOT);
            r_qw_reg <= qw_full[slt_pkg::RECIP_SHIFT +: 16];
            r_pw_reg <= d_pw_reg;
        end
    end

    assign turns2 = r_p1_reg[31:0] + 32'(r_qw_reg);

    slt_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic_rod (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (adv),
        .in_vld (r_vld_reg),
        .turns  (turns2),
        .flag   (r_pw_reg),
        .result (cs2)
    );

    // Scale by the arc radius
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            m2_vld_reg <= cs2.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m2_py_reg <= 50'(signed'({1'b0, radius_reg})) * 50'(cs2.cos_q30);
            m2_pz_reg <= 50'(signed'({1'b0, radius_reg})) * 50'(cs2.sin_q30);
            m2_pw_reg <= cs2.flag;
        end
    end

    // Round, offset, saturate into the output register
    assign ry = (m2_py_reg + 50'(slt_pkg::Q30_HALF)) >>> 30;
    assign rz = ((m2_pz_reg + 50'(slt_pkg::Q30_HALF)) >>> 30) + 50'(center_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (adv)
        begin
            out_valid <= m2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            foot_y       <= slt_pkg::sat18(ry);
            foot_z       <= slt_pkg::sat18(rz);
            power_stroke <= m2_pw_reg;
        end
    end

endmodule

`default_nettype wire

// File: design/slt_checker.sv
// ----------------------------------------------------------------------------
// slt_checker
// Port-level checks on the trajectory core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module slt_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic signed [17:0] foot_y,
    input wire logic signed [17:0] foot_z,
    input wire logic               power_stroke
);

    // Output word held while stalled
    `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(foot_y) && $stable(foot_z) && $stable(power_stroke), "output word changed while stalled")

    // Input side is ready exactly when the output register can move
    `ASSERT_CLK(a_ready_follow, clk, rst_n, in_ready == (!out_valid || out_ready), "input ready does not follow output register")

    // No word shown during reset
    `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |-> !out_valid, "output valid during reset")

endmodule

bind sculling_leg_trajectory_core slt_checker u_slt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .foot_y       (foot_y),
    .foot_z       (foot_z),
    .power_stroke (power_stroke)
);

`default_nettype wire

// File: tb/sculling_leg_trajectory_core_tb.sv
// ----------------------------------------------------------------------------
// sculling_leg_trajectory_core_tb
// Drives gait phases through the core under random idling on both sides,
// predicts each foot position with a CORDIC model of its own, and compares
// every result word field by field in order of acceptance.
// ----------------------------------------------------------------------------
`default_nettype none

module sculling_leg_trajectory_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES    = 16;
    localparam int FRAC_BITS = 16;
    localparam int LATENCY   = 2 * STAGES + 5;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [17:0] y;
        logic signed [17:0] z;
        logic               pwr;
    } foot_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_addr;
    logic [15:0]        cfg_wdata;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] gait_phase;
    logic               out_valid;
    logic               out_ready;
    logic signed [17:0] foot_y;
    logic signed [17:0] foot_z;
    logic               power_stroke;

    // Model copy of the registers
    longint amp_m;
    longint mean_m;
    longint centre_m;
    longint radius_m;

    logic [31:0] phase_q[$];
    foot_t       foot_q[$];
    int          fail_count;
    longint      cycle_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_off;

    sculling_leg_trajectory_core #(
        .CORDIC_STAGES(STAGES),
        .PHASE_FRAC_BITS(FRAC_BITS)
    ) dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_ready(in_ready),
        .gait_phase(gait_phase), .out_valid(out_valid), .out_ready(out_ready),
        .foot_y(foot_y), .foot_z(foot_z), .power_stroke(power_stroke)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint floor_shift(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint round_q30(input longint v);
        return (v + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic longint clamp18(input longint v);
        if (v > 131071)
        begin
            return 131071;
        end
        if (v < -131072)
        begin
            return -131072;
        end
        return v;
    endfunction

    // Rotate the gain-compensated unit vector by a binary-turn angle
    task automatic rotate_turns(input logic [31:0] turns, output longint c, output longint s);
        logic [31:0] t;
        logic [1:0]  quad;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        begin
            t = turns + slt_pkg::QUADRANT_OFFSET;
            quad = t[31:30];
            z = longint'({2'b0, t[29:0]}) - (64'sd1 <<< 29);
            x = 652032874;
            y = 0;
            for (int i = 0; i < STAGES && i < 24; i++)
            begin
                dx = floor_shift(y, i);
                dy = floor_shift(x, i);
                if (z >= 0)
                begin
                    x -= dx; y += dy; z -= longint'(slt_pkg::ATAN_TURNS[i]);
                end
                else
                begin
                    x += dx; y -= dy; z += longint'(slt_pkg::ATAN_TURNS[i]);
                end
            end
            case (quad)
                2'd0: begin c = x;  s = y;  end
                2'd1: begin c = -y; s = x;  end
                2'd2: begin c = -x; s = -y; end
                default: begin c = y; s = -x; end
            endcase
        end
    endtask

    // Work out the foot position for one phase word
    task automatic predict_foot(input logic [31:0] phase, output foot_t f);
        logic [31:0] turns1;
        logic [31:0] turns2;
        longint      c1, s1, c2, s2, delta, th, tm;
        logic [63:0] num;
        begin
            turns1 = (phase & ((32'd1 << FRAC_BITS) - 1)) << (32 - FRAC_BITS);
            rotate_turns(turns1, c1, s1);
            delta = round_q30(amp_m * s1);
            th = mean_m + delta;
            tm = th % 92160;
            if (tm < 0)
            begin
                tm += 92160;
            end
            num = (64'(tm) << 32) + 64'd46080;
            turns2 = 32'(num / 64'd92160);
            rotate_turns(turns2, c2, s2);
            f.y = 18'(clamp18(round_q30(radius_m * c2)));
            f.z = 18'(clamp18(centre_m + round_q30(radius_m * s2)));
            f.pwr = delta > 0;
        end
    endtask

    // Driver: offer queued phase words, hold each until taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gait_phase <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (phase_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                gait_phase <= phase_q.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Predict on acceptance
    always @(posedge clk)
    begin
        foot_t f;
        if (rst_n && in_valid && in_ready)
        begin
            predict_foot(gait_phase, f);
            foot_q.push_back(f);
        end
    end

    // Receiver readiness, with a long hold-off when asked
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_off > 0)
        begin
            out_ready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else
        begin
            out_ready <= $urandom_range(99) >= recv_idle_pct;
        end
    end

    // Monitor: compare each taken word with the oldest prediction
    always @(posedge clk)
    begin
        foot_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (foot_q.size() == 0)
            begin
                $error("unexpected result word y=%0d z=%0d", foot_y, foot_z);
                fail_count++;
            end
            else
            begin
                e = foot_q.pop_front();
                if (foot_y !== e.y)
                begin
                    $error("foot_y expected %0d actual %0d", e.y, foot_y);
                    fail_count++;
                end
                if (foot_z !== e.z)
                begin
                    $error("foot_z expected %0d actual %0d", e.z, foot_z);
                    fail_count++;
                end
                if (power_stroke !== e.pwr)
                begin
                    $error("power_stroke expected %0b actual %0b", e.pwr, power_stroke);
                    fail_count++;
                end
            end
        end
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic wait_drained();
        begin
            while (phase_q.size() > 0 || in_valid || foot_q.size() > 0)
            begin
                @(posedge clk);
            end
            repeat (LATENCY + 4) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        begin
            cfg_we <= 1'b1;
            cfg_addr <= idx;
            cfg_wdata <= val;
            @(posedge clk);
            cfg_we <= 1'b0;
            case (idx)
                slt_pkg::REG_SWING_AMPLITUDE: amp_m = val & 16'h7FFF;
                slt_pkg::REG_MEAN_ANGLE:      mean_m = longint'($signed(val));
                slt_pkg::REG_CENTER_HEIGHT:   centre_m = longint'($signed(val));
                default:                      radius_m = val;
            endcase
        end
    endtask

    task automatic set_all(input int a, input int m, input int c, input int r);
        begin
            write_reg(slt_pkg::REG_SWING_AMPLITUDE, 16'(a));
            write_reg(slt_pkg::REG_MEAN_ANGLE, 16'(m));
            write_reg(slt_pkg::REG_CENTER_HEIGHT, 16'(c));
            write_reg(slt_pkg::REG_ARC_RADIUS, 16'(r));
        end
    endtask

    // Mostly random phases, some at quadrant edges and with random integer part
    task automatic queue_random(input int n);
        logic [31:0] p;
        begin
            for (int i = 0; i < n; i++)
            begin
                p = $urandom;
                if ($urandom_range(4) == 0)
                begin
                    p[15:0] = 16'(($urandom_range(3) << 14) + $urandom_range(2) - 1);
                end
                phase_q.push_back(p);
            end
        end
    endtask

    initial
    begin
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        hold_off = 0;
        fail_count = 0;
        cycle_count = 0;
        send_idle_pct = 27;
        recv_idle_pct = 49;
        amp_m = 4608;
        mean_m = -4608;
        centre_m = -832;
        radius_m = 1616;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, phase extremes and quadrant points
        phase_q.push_back(32'h0000_0000);
        phase_q.push_back(32'h0000_4000);
        phase_q.push_back(32'h0000_8000);
        phase_q.push_back(32'h0000_C000);
        phase_q.push_back(32'h0000_FFFF);
        phase_q.push_back(32'h7FFF_FFFF);
        phase_q.push_back(32'h8000_0000);
        phase_q.push_back(32'hFFFF_FFFF);
        phase_q.push_back(32'hFFFF_4000);
        phase_q.push_back(32'h1234_0001);
        wait_drained();

        // Extremes: wide swing wrapping past half a turn, largest radius and centre heights
        set_all(23040, 23040, 32767, 65535);
        for (int i = 0; i < 4; i++) phase_q.push_back(32'(i << 14));
        phase_q.push_back(32'hAAAA_5555);
        wait_drained();
        set_all(23040, -23040, -32768, 65535);
        for (int i = 0; i < 4; i++) phase_q.push_back(32'(i << 14));
        wait_drained();
        set_all(0, 0, 0, 0);
        phase_q.push_back(32'h0000_4000);
        phase_q.push_back(32'h5555_AAAA);
        wait_drained();
        // Raw 16-bit value with the top bit set on the amplitude register
        set_all(32'hFFFF, 32'h7FFF, 32'h8000, 32'hFFFF);
        phase_q.push_back(32'h0000_2000);
        phase_q.push_back(32'h0000_6000);
        wait_drained();

        // Random phases under varying settings and idling
        for (int ph = 0; ph < 9; ph++)
        begin
            if (ph == 3)
            begin
                send_idle_pct = 49;
                recv_idle_pct = 27;
            end
            else if (ph == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_all($urandom_range(23040), $urandom_range(46080) - 23040,
                    $urandom_range(65535), $urandom_range(65535));
            if (ph == 4)
            begin
                hold_off = 3 * LATENCY;
            end
            queue_random(150);
            wait_drained();
        end

        if (fail_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
